// File: hdl/bcep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcep_pkg: shared types and helpers of the boot configuration entry parser
// Limits, status codes, parse phases, character classes and the result word.
// ----------------------------------------------------------------------------
package bcep_pkg;

    // text and table limits
    localparam int MAX_BYTES   = 4096;
    localparam int MAX_ENTRIES = 256;

    // byte position reaches MAX_BYTES itself, entry count reaches MAX_ENTRIES
    localparam int POS_W = $clog2(MAX_BYTES + 1);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // fixed field widths of a result word
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 8;
    localparam int SPAN_W   = 12;

    // length of the kernel name
    localparam logic [2:0] KWORD_LEN = 3'd6;

    // special characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENTRY     = 3'd0,
        ST_DONE      = 3'd1,
        ST_SYNTAX    = 3'd2,
        ST_NO_KERNEL = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_LEAD = 7'b0000010,
        PH_NAME = 7'b0000100,
        PH_GAP1 = 7'b0001000,
        PH_GAP2 = 7'b0010000,
        PH_PATH = 7'b0100000,
        PH_HALT = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  entry_index;
        logic [SPAN_W-1:0]   name_offset;
        logic [SPAN_W-1:0]   name_length;
        logic [SPAN_W-1:0]   path_offset;
        logic [SPAN_W-1:0]   path_length;
        logic                is_kernel;
        logic [INDEX_W-1:0]  kernel_index;
        logic                last;
    } t_result;

    // space, tab, lf, vt, ff, cr
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_name_ch(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7a)) ||
               ((c >= 8'h41) && (c <= 8'h5a)) || (c == CH_UNDER) ||
               (c == CH_DASH) || (c == CH_DOT);
    endfunction

    function automatic logic is_path_ch(input logic [7:0] c);
        return is_name_ch(c) || (c == CH_BSLASH) || (c == CH_SLASH);
    endfunction

    // characters of the name "kernel"
    function automatic logic [7:0] kword(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h6b;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h72;
            3'd3:    ch = 8'h6e;
            3'd4:    ch = 8'h65;
            3'd5:    ch = 8'h6c;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // one step of the kernel name match: returns {broken, progress}
    function automatic logic [3:0] match_step(input logic [2:0] mp, input logic mb,
                                              input logic [7:0] c);
        logic [3:0] r;
        r = {mb, mp};
        if (!mb) begin
            if ((mp < KWORD_LEN) && (c == kword(mp))) begin
                r = {1'b0, mp + 3'd1};
            end else begin
                r = {1'b1, mp};
            end
        end
        return r;
    endfunction

endpackage

// File: hdl/bcep_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcep_in_if: text byte channel
// Valid/ready channel carrying one text byte and its restart flag per word.
// ----------------------------------------------------------------------------
interface bcep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// File: hdl/bcep_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcep_out_if: parse result channel
// Valid/ready channel carrying one entry, done or error report per word.
// ----------------------------------------------------------------------------
interface bcep_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  entry_index;
    logic [11:0] name_offset;
    logic [11:0] name_length;
    logic [11:0] path_offset;
    logic [11:0] path_length;
    logic        is_kernel;
    logic [7:0]  kernel_index;
    logic        last;

    modport source (output valid, output status, output entry_index, output name_offset,
                    output name_length, output path_offset, output path_length,
                    output is_kernel, output kernel_index, output last, input ready);
    modport sink   (input valid, input status, input entry_index, input name_offset,
                    input name_length, input path_offset, input path_length,
                    input is_kernel, input kernel_index, input last, output ready);
endinterface

// File: hdl/boot_config_entry_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot_config_entry_parser_top: boot configuration entry parser
// Splits a zero-terminated configuration text into name:path entries.
// ----------------------------------------------------------------------------
// One text byte is taken per clock. Each byte is classified and the parse
// state updated in the cycle it is accepted; the zero, one or two result
// words it causes go into a four-word result queue and leave at one word per
// cycle while the receiver is ready, so the input keeps running as long as
// the queue holds two or fewer words. A byte with first_byte set restarts the
// parse at offset zero from any state; after done or an error further bytes
// are swallowed until such a restart. Offsets and lengths are the low 12 bits
// and indexes the low 8 bits of the internal counters.
// ----------------------------------------------------------------------------
module boot_config_entry_parser_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bcep_in_if.sink      i_in,
    bcep_out_if.source   o_out
);

    // parse state
    bcep_pkg::t_phase                  r_phase,    n_phase;
    logic [bcep_pkg::POS_W-1:0]        r_pos,      n_pos;
    logic [bcep_pkg::POS_W-1:0]        r_name_st,  n_name_st;
    logic [bcep_pkg::POS_W-1:0]        r_name_sz,  n_name_sz;
    logic [bcep_pkg::POS_W-1:0]        r_path_st,  n_path_st;
    logic [bcep_pkg::CNT_W-1:0]        r_ent_cnt,  n_ent_cnt;
    logic                              r_k_seen,   n_k_seen;
    logic [bcep_pkg::INDEX_W-1:0]      r_k_entry,  n_k_entry;
    logic [2:0]                        r_m_prog,   n_m_prog;
    logic                              r_m_brk,    n_m_brk;

    // result queue
    bcep_pkg::t_result                 r_fifo [bcep_pkg::FIFO_DEPTH];
    logic [bcep_pkg::FIFO_AW-1:0]      r_wr_ptr, r_rd_ptr;
    logic [bcep_pkg::FIFO_CW-1:0]      r_count;

    logic                              in_acc;
    logic                              out_acc;
    bcep_pkg::t_result                 res0, res1;
    logic [1:0]                        push_n;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    // room for the two words a byte may cause
    assign i_in.ready = (r_count <= bcep_pkg::FIFO_CW'(bcep_pkg::FIFO_DEPTH - 2));

    // byte classification and phase transition
    always_comb begin
        logic [7:0]                   c;
        logic                         emit_entry;
        logic                         emit_stop;
        logic                         do_lead;
        logic                         isk;
        logic [3:0]                   mstep;
        bcep_pkg::t_status            stop_st;
        bcep_pkg::t_result            ent_res;
        bcep_pkg::t_result            stop_res;

        c          = i_in.data_byte;
        emit_entry = 1'b0;
        emit_stop  = 1'b0;
        do_lead    = 1'b0;
        isk        = 1'b0;
        mstep      = '0;
        stop_st    = bcep_pkg::ST_SYNTAX;
        ent_res    = '0;
        stop_res   = '0;

        n_phase   = r_phase;
        n_pos     = r_pos;
        n_name_st = r_name_st;
        n_name_sz = r_name_sz;
        n_path_st = r_path_st;
        n_ent_cnt = r_ent_cnt;
        n_k_seen  = r_k_seen;
        n_k_entry = r_k_entry;
        n_m_prog  = r_m_prog;
        n_m_brk   = r_m_brk;

        if (in_acc && (i_in.first_byte ||
                       !((r_phase == bcep_pkg::PH_IDLE) || (r_phase == bcep_pkg::PH_HALT)))) begin
            // restart clears everything
            if (i_in.first_byte) begin
                n_phase   = bcep_pkg::PH_LEAD;
                n_pos     = '0;
                n_name_st = '0;
                n_name_sz = '0;
                n_path_st = '0;
                n_ent_cnt = '0;
                n_k_seen  = 1'b0;
                n_k_entry = '0;
                n_m_prog  = '0;
                n_m_brk   = 1'b0;
            end

            if (n_pos >= bcep_pkg::POS_W'(bcep_pkg::MAX_BYTES)) begin
                // byte length overflow
                emit_stop = 1'b1;
                stop_st   = bcep_pkg::ST_OVERFLOW;
            end else begin
                unique case (n_phase)
                    bcep_pkg::PH_LEAD: begin
                        do_lead = 1'b1;
                    end
                    bcep_pkg::PH_NAME: begin
                        if (bcep_pkg::is_name_ch(c)) begin
                            mstep    = bcep_pkg::match_step(n_m_prog, n_m_brk, c);
                            n_m_brk  = mstep[3];
                            n_m_prog = mstep[2:0];
                        end else begin
                            n_name_sz = n_pos - n_name_st;
                            if (bcep_pkg::is_ws(c)) begin
                                n_phase = bcep_pkg::PH_GAP1;
                            end else if (c == bcep_pkg::CH_COLON) begin
                                n_phase = bcep_pkg::PH_GAP2;
                            end else begin
                                emit_stop = 1'b1;
                            end
                        end
                    end
                    bcep_pkg::PH_GAP1: begin
                        if (c == bcep_pkg::CH_COLON) begin
                            n_phase = bcep_pkg::PH_GAP2;
                        end else if (!bcep_pkg::is_ws(c)) begin
                            emit_stop = 1'b1;
                        end
                    end
                    bcep_pkg::PH_GAP2: begin
                        if (bcep_pkg::is_path_ch(c)) begin
                            n_path_st = n_pos;
                            n_phase   = bcep_pkg::PH_PATH;
                        end else if (!bcep_pkg::is_ws(c)) begin
                            emit_stop = 1'b1;
                        end
                    end
                    bcep_pkg::PH_PATH: begin
                        if (!bcep_pkg::is_path_ch(c)) begin
                            if (n_ent_cnt >= bcep_pkg::CNT_W'(bcep_pkg::MAX_ENTRIES)) begin
                                // entry table overflow
                                emit_stop = 1'b1;
                                stop_st   = bcep_pkg::ST_OVERFLOW;
                            end else begin
                                isk = !n_m_brk && (n_m_prog == bcep_pkg::KWORD_LEN);
                                if (isk && !n_k_seen) begin
                                    n_k_seen  = 1'b1;
                                    n_k_entry = bcep_pkg::INDEX_W'(n_ent_cnt);
                                end
                                emit_entry           = 1'b1;
                                ent_res.status       = bcep_pkg::ST_ENTRY;
                                ent_res.entry_index  = bcep_pkg::INDEX_W'(n_ent_cnt);
                                ent_res.name_offset  = bcep_pkg::SPAN_W'(n_name_st);
                                ent_res.name_length  = bcep_pkg::SPAN_W'(n_name_sz);
                                ent_res.path_offset  = bcep_pkg::SPAN_W'(n_path_st);
                                ent_res.path_length  = bcep_pkg::SPAN_W'(n_pos - n_path_st);
                                ent_res.is_kernel    = isk;
                                n_ent_cnt            = n_ent_cnt + 1'b1;
                                do_lead              = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = bcep_pkg::PH_HALT;
                    end
                endcase

                // start of an entry, also for the byte that ends a path
                if (do_lead) begin
                    if (bcep_pkg::is_ws(c)) begin
                        n_phase = bcep_pkg::PH_LEAD;
                    end else if (c == bcep_pkg::CH_NUL) begin
                        emit_stop = 1'b1;
                        stop_st   = n_k_seen ? bcep_pkg::ST_DONE : bcep_pkg::ST_NO_KERNEL;
                    end else if (bcep_pkg::is_name_ch(c)) begin
                        n_name_st = n_pos;
                        mstep     = bcep_pkg::match_step(3'd0, 1'b0, c);
                        n_m_brk   = mstep[3];
                        n_m_prog  = mstep[2:0];
                        n_phase   = bcep_pkg::PH_NAME;
                    end else begin
                        emit_stop = 1'b1;
                        stop_st   = bcep_pkg::ST_SYNTAX;
                    end
                end

                n_pos = n_pos + 1'b1;
            end

            if (emit_stop) begin
                n_phase = bcep_pkg::PH_HALT;
            end
        end

        // done and error report
        stop_res.status       = stop_st;
        stop_res.entry_index  = bcep_pkg::INDEX_W'(n_ent_cnt);
        stop_res.kernel_index = (stop_st == bcep_pkg::ST_DONE) ? n_k_entry : '0;
        stop_res.last         = 1'b1;

        // order the words: entry first, report after
        res0   = '0;
        res1   = stop_res;
        push_n = 2'd0;
        if (emit_entry) begin
            res0      = ent_res;
            res0.last = !emit_stop;
            push_n    = emit_stop ? 2'd2 : 2'd1;
        end else if (emit_stop) begin
            res0   = stop_res;
            push_n = 2'd1;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bcep_pkg::PH_IDLE;
            r_pos     <= '0;
            r_name_st <= '0;
            r_name_sz <= '0;
            r_path_st <= '0;
            r_ent_cnt <= '0;
            r_k_seen  <= 1'b0;
            r_k_entry <= '0;
            r_m_prog  <= '0;
            r_m_brk   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_name_st <= n_name_st;
            r_name_sz <= n_name_sz;
            r_path_st <= n_path_st;
            r_ent_cnt <= n_ent_cnt;
            r_k_seen  <= n_k_seen;
            r_k_entry <= n_k_entry;
            r_m_prog  <= n_m_prog;
            r_m_brk   <= n_m_brk;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + 1'b1] <= res1;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + bcep_pkg::FIFO_AW'(push_n);
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + bcep_pkg::FIFO_CW'(push_n)
                       - bcep_pkg::FIFO_CW'(out_acc);
        end
    end

    // output word
    assign o_out.valid        = (r_count != '0);
    assign o_out.status       = r_fifo[r_rd_ptr].status;
    assign o_out.entry_index  = r_fifo[r_rd_ptr].entry_index;
    assign o_out.name_offset  = r_fifo[r_rd_ptr].name_offset;
    assign o_out.name_length  = r_fifo[r_rd_ptr].name_length;
    assign o_out.path_offset  = r_fifo[r_rd_ptr].path_offset;
    assign o_out.path_length  = r_fifo[r_rd_ptr].path_length;
    assign o_out.is_kernel    = r_fifo[r_rd_ptr].is_kernel;
    assign o_out.kernel_index = r_fifo[r_rd_ptr].kernel_index;
    assign o_out.last         = r_fifo[r_rd_ptr].last;

endmodule

// File: test/bcep_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcep_result_checker: scoreboard of the boot configuration entry parser
// Watches the text and result channels, keeps its own copy of the parse
// state, works out the result words of every accepted text byte and compares
// each accepted result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module bcep_result_checker
    import bcep_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bcep_in_if   i_text,
    bcep_out_if  i_result,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_word_count
);

    // the name that marks a kernel entry, first character at index 0
    localparam logic [0:5][7:0] KERNEL_NAME = "kernel";

    // parse state of the prediction
    t_phase             phase_q;
    logic [POS_W-1:0]   text_pos;
    logic [POS_W-1:0]   name_pos;
    logic [POS_W-1:0]   name_len;
    logic [POS_W-1:0]   path_pos;
    logic [CNT_W-1:0]   entry_cnt;
    logic               kernel_found;
    logic [INDEX_W-1:0] kernel_idx;
    logic [2:0]         kmatch_len;
    logic               kmatch_lost;

    t_result            predicted_words [$];

    // character classes
    function automatic logic blank_char(input logic [7:0] c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    function automatic logic name_char(input logic [7:0] c);
        return c inside {["0":"9"], ["a":"z"], ["A":"Z"], CH_UNDER, CH_DASH, CH_DOT};
    endfunction

    function automatic logic path_char(input logic [7:0] c);
        return name_char(c) || (c == CH_SLASH) || (c == CH_BSLASH);
    endfunction

    task automatic restart_parse();
        phase_q      = PH_IDLE;
        text_pos     = '0;
        name_pos     = '0;
        name_len     = '0;
        path_pos     = '0;
        entry_cnt    = '0;
        kernel_found = 1'b0;
        kernel_idx   = '0;
        kmatch_len   = '0;
        kmatch_lost  = 1'b0;
    endtask

    task automatic push_word(input t_status st, input logic [INDEX_W-1:0] idx,
                             input logic [SPAN_W-1:0] n_off, input logic [SPAN_W-1:0] n_len,
                             input logic [SPAN_W-1:0] p_off, input logic [SPAN_W-1:0] p_len,
                             input logic isk, input logic [INDEX_W-1:0] kidx);
        t_result w;
        w.status       = st;
        w.entry_index  = idx;
        w.name_offset  = n_off;
        w.name_length  = n_len;
        w.path_offset  = p_off;
        w.path_length  = p_len;
        w.is_kernel    = isk;
        w.kernel_index = kidx;
        w.last         = 1'b0;
        predicted_words.push_back(w);
    endtask

    // done or error report, then bytes are swallowed until a restart
    task automatic halt_parse(input t_status st);
        push_word(st, entry_cnt[INDEX_W-1:0], '0, '0, '0, '0, 1'b0,
                  (st == ST_DONE) ? kernel_idx : '0);
        phase_q = PH_HALT;
    endtask

    task automatic track_kernel(input logic [7:0] c);
        if (!kmatch_lost) begin
            if ((kmatch_len < KWORD_LEN) && (c == KERNEL_NAME[kmatch_len])) begin
                kmatch_len = kmatch_len + 3'd1;
            end else begin
                kmatch_lost = 1'b1;
            end
        end
    endtask

    // a byte where an entry may begin
    task automatic open_entry(input logic [7:0] c);
        if (blank_char(c)) begin
            phase_q = PH_LEAD;
        end else if (c == CH_NUL) begin
            halt_parse(kernel_found ? ST_DONE : ST_NO_KERNEL);
        end else if (name_char(c)) begin
            name_pos    = text_pos;
            kmatch_len  = '0;
            kmatch_lost = 1'b0;
            track_kernel(c);
            phase_q     = PH_NAME;
        end else begin
            halt_parse(ST_SYNTAX);
        end
    endtask

    // one accepted text byte: update the parse and queue its result words
    task automatic advance_parse(input logic [7:0] c, input logic restart);
        int               queued_at_start;
        logic [POS_W-1:0] path_len;
        logic             isk;
        t_result          w;
        queued_at_start = predicted_words.size();
        if (restart) begin
            restart_parse();
            phase_q = PH_LEAD;
        end
        if ((phase_q == PH_IDLE) || (phase_q == PH_HALT)) begin
            return;
        end
        if (text_pos >= POS_W'(MAX_BYTES)) begin
            halt_parse(ST_OVERFLOW);
        end else begin
            case (phase_q)
                PH_LEAD: begin
                    open_entry(c);
                end
                PH_NAME: begin
                    if (name_char(c)) begin
                        track_kernel(c);
                    end else begin
                        name_len = text_pos - name_pos;
                        if (blank_char(c)) begin
                            phase_q = PH_GAP1;
                        end else if (c == CH_COLON) begin
                            phase_q = PH_GAP2;
                        end else begin
                            halt_parse(ST_SYNTAX);
                        end
                    end
                end
                PH_GAP1: begin
                    if (c == CH_COLON) begin
                        phase_q = PH_GAP2;
                    end else if (!blank_char(c)) begin
                        halt_parse(ST_SYNTAX);
                    end
                end
                PH_GAP2: begin
                    if (path_char(c)) begin
                        path_pos = text_pos;
                        phase_q  = PH_PATH;
                    end else if (!blank_char(c)) begin
                        halt_parse(ST_SYNTAX);
                    end
                end
                PH_PATH: begin
                    // the byte that ends a path also opens the next entry
                    if (!path_char(c)) begin
                        if (entry_cnt >= CNT_W'(MAX_ENTRIES)) begin
                            halt_parse(ST_OVERFLOW);
                        end else begin
                            isk = !kmatch_lost && (kmatch_len == KWORD_LEN);
                            if (isk && !kernel_found) begin
                                kernel_found = 1'b1;
                                kernel_idx   = entry_cnt[INDEX_W-1:0];
                            end
                            path_len = text_pos - path_pos;
                            push_word(ST_ENTRY, entry_cnt[INDEX_W-1:0],
                                      name_pos[SPAN_W-1:0], name_len[SPAN_W-1:0],
                                      path_pos[SPAN_W-1:0], path_len[SPAN_W-1:0],
                                      isk, '0);
                            entry_cnt = entry_cnt + 1'b1;
                            open_entry(c);
                        end
                    end
                end
                default: begin
                    phase_q = PH_HALT;
                end
            endcase
            text_pos = text_pos + 1'b1;
        end
        // flag the final word caused by this byte
        if (predicted_words.size() > queued_at_start) begin
            w      = predicted_words.pop_back();
            w.last = 1'b1;
            predicted_words.push_back(w);
        end
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, got);
            o_fail_count++;
        end
    endtask

    task automatic compare_word();
        t_result want;
        if (predicted_words.size() == 0) begin
            $error("result word with nothing predicted: status %0d entry_index %0d",
                   i_result.status, i_result.entry_index);
            o_fail_count++;
        end else begin
            want = predicted_words.pop_front();
            check_field("status",       want.status,       i_result.status);
            check_field("entry_index",  want.entry_index,  i_result.entry_index);
            check_field("name_offset",  want.name_offset,  i_result.name_offset);
            check_field("name_length",  want.name_length,  i_result.name_length);
            check_field("path_offset",  want.path_offset,  i_result.path_offset);
            check_field("path_length",  want.path_length,  i_result.path_length);
            check_field("is_kernel",    want.is_kernel,    i_result.is_kernel);
            check_field("kernel_index", want.kernel_index, i_result.kernel_index);
            check_field("last",         want.last,         i_result.last);
        end
        o_word_count++;
    endtask

    // results are compared before the byte of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_parse();
            predicted_words.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                compare_word();
            end
            if (i_text.valid && i_text.ready) begin
                advance_parse(i_text.data_byte, i_text.first_byte);
            end
        end
        o_pending = predicted_words.size();
    end

endmodule

// File: test/tb_boot_config_entry_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_boot_config_entry_parser_top: testbench of the boot configuration parser
// Feeds short directed texts for each error and edge case, then random texts
// (mostly well formed, some damaged, cut short or followed by stray bytes)
// under three idling mixes, and finally long texts that reach the offset,
// entry table and text length limits. The checker scores every result word.
// ----------------------------------------------------------------------------
module tb_boot_config_entry_parser_top;
    import bcep_pkg::*;

    logic       i_clk;
    logic       i_rst_n;

    int         tx_idle_pct;
    int         rx_idle_pct;
    int         texts_sent;
    int         bytes_sent;
    int         random_bytes;
    int         fail_count;
    int         pending_words;
    int         words_checked;

    logic [7:0] text_bytes [$];

    logic [7:0] blank_chars [6] = '{CH_SPACE, CH_TAB, 8'h0a, 8'h0b, 8'h0c, CH_CR};
    logic [7:0] punct_chars [3] = '{CH_UNDER, CH_DASH, CH_DOT};
    string      near_names [5]  = '{"kerne", "kernelx", "Kernel", "kernell", "kern_el"};

    bcep_in_if  in_ch ();
    bcep_out_if out_ch ();

    boot_config_entry_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bcep_result_checker result_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text       (in_ch),
        .i_result     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_words),
        .o_word_count (words_checked)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2ms;
        $display("timeout: parser stopped making progress");
        $display("== FAIL ==");
        $finish;
    end

    // result side back-pressure
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // one word on the text channel, with random gaps in front of it
    task automatic send_byte(input logic [7:0] b, input logic restart);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.first_byte <= restart;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_bytes[k]) begin
            send_byte(text_bytes[k], k == 0);
        end
        texts_sent++;
    endtask

    task automatic load_string(input string s);
        for (int k = 0; k < s.len(); k++) begin
            text_bytes.push_back(s[k]);
        end
    endtask

    task automatic run_text(input string s, input logic terminate);
        text_bytes.delete();
        load_string(s);
        if (terminate) begin
            text_bytes.push_back(CH_NUL);
        end
        send_text();
    endtask

    function automatic logic [7:0] random_name_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = "a" + 8'($urandom_range(0, 25));
            1:       c = "A" + 8'($urandom_range(0, 25));
            2:       c = "0" + 8'($urandom_range(0, 9));
            default: c = punct_chars[$urandom_range(0, 2)];
        endcase
        return c;
    endfunction

    function automatic logic [7:0] random_path_char();
        logic [7:0] c;
        if ($urandom_range(0, 5) == 0) begin
            c = ($urandom_range(0, 1) == 0) ? CH_SLASH : CH_BSLASH;
        end else begin
            c = random_name_char();
        end
        return c;
    endfunction

    task automatic add_blanks(input int n);
        repeat (n) text_bytes.push_back(blank_chars[$urandom_range(0, 5)]);
    endtask

    task automatic add_name();
        case ($urandom_range(0, 9))
            0, 1:    load_string("kernel");
            2:       load_string(near_names[$urandom_range(0, 4)]);
            default: repeat ($urandom_range(1, 6)) text_bytes.push_back(random_name_char());
        endcase
    endtask

    task automatic add_path(input int n);
        repeat (n) text_bytes.push_back(random_path_char());
    endtask

    // a text of a few entries, now and then damaged or cut short
    task automatic random_text();
        int n_entries;
        int spot;
        n_entries = $urandom_range(0, 5);
        text_bytes.delete();
        for (int e = 0; e < n_entries; e++) begin
            add_blanks($urandom_range(0, 2));
            add_name();
            add_blanks($urandom_range(0, 2));
            text_bytes.push_back(CH_COLON);
            add_blanks($urandom_range(0, 2));
            add_path($urandom_range(1, 8));
            if ((e < n_entries - 1) || ($urandom_range(0, 1) == 0)) begin
                add_blanks(1);
            end
        end
        text_bytes.push_back(CH_NUL);
        if ($urandom_range(0, 3) == 0) begin
            spot = $urandom_range(0, text_bytes.size() - 1);
            case ($urandom_range(0, 4))
                0:       text_bytes[spot] = 8'($urandom_range(0, 255));
                1:       text_bytes[spot] = CH_COLON;
                2:       text_bytes[spot] = CH_SPACE;
                3:       text_bytes[spot] = CH_NUL;
                // cut short: the next text restarts the parse midway
                default: while (text_bytes.size() > spot + 1) void'(text_bytes.pop_back());
            endcase
        end
        random_bytes += text_bytes.size();
        send_text();
        // stray words, mostly swallowed after done or an error
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // stimulus
    initial begin
        tx_idle_pct      = 33;
        rx_idle_pct      = 54;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.data_byte  <= '0;
        in_ch.first_byte <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases
        send_byte(8'hff, 1'b0);             // ignored before any restart
        run_text("kernel:a", 1'b1);         // entry and done on the terminator
        run_text(":", 1'b0);                // empty name
        run_text("a b", 1'b0);              // missing colon
        send_byte(CH_NUL, 1'b0);            // swallowed after the error
        run_text("a:", 1'b1);               // empty path at the terminator
        run_text("x:y:", 1'b0);             // entry and error on one byte
        send_byte(8'hff, 1'b1);             // bad character where a name begins
        run_text("a", 1'b1);                // terminator instead of a colon
        run_text("", 1'b1);                 // empty text, no kernel
        run_text("ab", 1'b0);               // restart in the middle of a name
        run_text("k:p", 1'b1);

        // random texts under the three idling mixes
        while (random_bytes < 170) random_text();
        tx_idle_pct = 54;
        rx_idle_pct = 33;
        while (random_bytes < 340) random_text();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (random_bytes < 500) random_text();

        // entry table overflow on the entry after the last slot
        text_bytes.delete();
        for (int i = 0; i <= MAX_ENTRIES; i++) begin
            if (i == 200) begin
                load_string("kernel");
            end else begin
                text_bytes.push_back(random_name_char());
            end
            text_bytes.push_back(CH_COLON);
            text_bytes.push_back(random_path_char());
            add_blanks(1);
        end
        text_bytes.push_back(CH_NUL);
        send_text();

        // entry close to the end of the text
        text_bytes.delete();
        add_blanks(MAX_BYTES - 26);
        load_string("kernel : /b\\x.y");
        text_bytes.push_back(CH_NUL);
        send_text();

        // long name and path spans
        text_bytes.delete();
        add_blanks(2);
        repeat (1500) text_bytes.push_back(random_name_char());
        text_bytes.push_back(CH_COLON);
        add_path(2500);
        text_bytes.push_back(CH_NUL);
        send_text();

        // length overflow inside a path
        text_bytes.delete();
        load_string("k:");
        add_path(MAX_BYTES + 100);
        text_bytes.push_back(CH_NUL);
        send_text();

        // length overflow on the terminator itself
        text_bytes.delete();
        add_blanks(MAX_BYTES);
        text_bytes.push_back(CH_NUL);
        send_text();

        // drain and verdict
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        $display("covered %0d texts, %0d text bytes and %0d result words over three idling mixes",
                 texts_sent, bytes_sent, words_checked);
        $display("including each syntax error, both overflow kinds, restarts and ignored bytes");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
